[rtl/encoder_menu_navigator_macros.svh]
// Assertion macros used by the encoder menu navigator checker.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef ENCODER_MENU_NAVIGATOR_MACROS_SVH
`define ENCODER_MENU_NAVIGATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ENM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("encoder menu navigator: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ENM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("encoder menu navigator: assertion failed");

`endif

[rtl/enm_pkg.sv]
`timescale 1ns / 1ps
// Package of the encoder menu navigator: command codes, register indexes,
// beat types and the fixed menu transition table. Depends on nothing.
package enm_pkg;

	localparam int MenuCount = 26;

	// Applied command codes.
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_CW     = 3'd1;
	localparam logic [2:0] CMD_CCW    = 3'd2;
	localparam logic [2:0] CMD_SELECT = 3'd3;
	localparam logic [2:0] CMD_BACK   = 3'd4;

	// Encoder rotation codes.
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CW   = 2'd1;
	localparam logic [1:0] ROT_CCW  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_POSITION_LOW  = 1'b0;
	localparam logic REG_POSITION_HIGH = 1'b1;

	localparam logic [7:0] POSITION_LOW_RESET  = 8'd0;
	localparam logic [7:0] POSITION_HIGH_RESET = 8'd9;

	// Received character codes.
	localparam logic [7:0] CHAR_RIGHT  = 8'h64; // 'd'
	localparam logic [7:0] CHAR_LEFT   = 8'h61; // 'a'
	localparam logic [7:0] CHAR_SELECT = 8'h77; // 'w'
	localparam logic [7:0] CHAR_BACK   = 8'h73; // 's'

	localparam logic [4:0] MENU_TOP = 5'd0;

	typedef struct packed {
		logic       clock_pin;
		logic       data_pin;
		logic       switch_pin;
		logic       char_valid;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic [4:0] menu_state;
		logic       state_changed;
		logic [2:0] command;
		logic [1:0] rotation;
		logic [7:0] position;
	} result_t;

	typedef struct packed {
		logic [7:0] position_low;
		logic [7:0] position_high;
	} cfg_t;

	// Next state per menu state, columns: clockwise, counter-clockwise, select, back.
	localparam logic [4:0] MENU_NEXT [MenuCount][4] = '{
		'{5'd7,  5'd14, 5'd1,  5'd0},
		'{5'd2,  5'd3,  5'd4,  5'd0},
		'{5'd3,  5'd1,  5'd5,  5'd0},
		'{5'd1,  5'd2,  5'd6,  5'd0},
		'{5'd4,  5'd4,  5'd4,  5'd1},
		'{5'd5,  5'd5,  5'd5,  5'd2},
		'{5'd6,  5'd6,  5'd6,  5'd3},
		'{5'd14, 5'd0,  5'd8,  5'd7},
		'{5'd9,  5'd10, 5'd11, 5'd7},
		'{5'd10, 5'd8,  5'd12, 5'd7},
		'{5'd8,  5'd9,  5'd13, 5'd7},
		'{5'd11, 5'd11, 5'd11, 5'd8},
		'{5'd12, 5'd12, 5'd12, 5'd9},
		'{5'd13, 5'd13, 5'd13, 5'd10},
		'{5'd0,  5'd7,  5'd15, 5'd14},
		'{5'd16, 5'd17, 5'd18, 5'd14},
		'{5'd17, 5'd15, 5'd19, 5'd14},
		'{5'd15, 5'd16, 5'd20, 5'd14},
		'{5'd18, 5'd18, 5'd18, 5'd15},
		'{5'd19, 5'd19, 5'd19, 5'd16},
		'{5'd21, 5'd22, 5'd23, 5'd17},
		'{5'd22, 5'd20, 5'd24, 5'd17},
		'{5'd20, 5'd21, 5'd25, 5'd17},
		'{5'd23, 5'd23, 5'd23, 5'd20},
		'{5'd24, 5'd24, 5'd24, 5'd21},
		'{5'd25, 5'd25, 5'd25, 5'd22}
	};

	// Map a received character to a command; any other byte cancels.
	function automatic logic [2:0] char_command(input logic [7:0] code);
		logic [2:0] cmd;
		case (code)
			CHAR_RIGHT:  cmd = CMD_CW;
			CHAR_LEFT:   cmd = CMD_CCW;
			CHAR_SELECT: cmd = CMD_SELECT;
			CHAR_BACK:   cmd = CMD_BACK;
			default:     cmd = CMD_NONE;
		endcase
		return cmd;
	endfunction

	// Menu transition; no command or an unknown state leaves the state as is.
	function automatic logic [4:0] menu_next(input logic [4:0] cur, input logic [2:0] cmd);
		logic [4:0] nxt;
		logic [1:0] col;
		col = 2'(cmd - 3'd1);
		if (cmd == CMD_NONE || cmd > CMD_BACK || cur >= 5'(MenuCount)) begin
			nxt = cur;
		end else begin
			nxt = MENU_NEXT[cur][col];
		end
		return nxt;
	endfunction

endpackage

[rtl/enm_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration registers of the encoder menu navigator: position bounds.
// Depends on enm_pkg.
module enm_cfg_regs import enm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	logic [7:0] position_low_q;
	logic [7:0] position_high_q;

	// Decode the write index and update the addressed bound.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_low_q  <= POSITION_LOW_RESET;
			position_high_q <= POSITION_HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POSITION_LOW:  position_low_q  <= cfg_data;
				REG_POSITION_HIGH: position_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.position_low  = position_low_q;
	assign cfg.position_high = position_high_q;

endmodule

[rtl/enm_step_core.sv]
`timescale 1ns / 1ps
// Per-poll step of the encoder menu navigator: edge detection, wrapped position
// counter and menu table lookup, with the state it keeps. Depends on enm_pkg.
module enm_step_core import enm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  in_item_t item,
	input  cfg_t     cfg,
	output result_t  result
);

	logic       clock_last_q;
	logic       switch_last_q;
	logic [7:0] position_q;
	logic [4:0] menu_q;

	logic       rise_clock;
	logic       rise_switch;
	logic       step_cw;
	logic [7:0] position_next;
	logic [1:0] rot;
	logic [2:0] cmd;
	logic [4:0] menu_next_w;

	// Encoder step and the wrapped position counter.
	always_comb begin
		rise_clock    = item.clock_pin && !clock_last_q;
		step_cw       = item.data_pin != item.clock_pin;
		position_next = position_q;
		rot           = ROT_NONE;
		if (rise_clock) begin
			if (step_cw) begin
				rot = ROT_CW;
				if (position_q >= cfg.position_high) begin
					position_next = cfg.position_low;
				end else begin
					position_next = position_q + 8'd1;
				end
			end else begin
				rot = ROT_CCW;
				if (position_q <= cfg.position_low) begin
					position_next = cfg.position_high;
				end else begin
					position_next = position_q - 8'd1;
				end
			end
		end
	end

	// Command priority: character over switch over encoder.
	always_comb begin
		rise_switch = item.switch_pin && !switch_last_q;
		if (item.char_valid) begin
			cmd = char_command(item.char_code);
		end else if (rise_switch) begin
			cmd = CMD_SELECT;
		end else if (rot == ROT_CW) begin
			cmd = CMD_CW;
		end else if (rot == ROT_CCW) begin
			cmd = CMD_CCW;
		end else begin
			cmd = CMD_NONE;
		end
		menu_next_w = menu_next(menu_q, cmd);
	end

	// State moves only when the beat leaves for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_last_q  <= 1'b0;
			switch_last_q <= 1'b0;
			position_q    <= 8'd0;
			menu_q        <= MENU_TOP;
		end else if (advance) begin
			clock_last_q  <= item.clock_pin;
			switch_last_q <= item.switch_pin;
			position_q    <= position_next;
			menu_q        <= menu_next_w;
		end
	end

	assign result.menu_state    = menu_next_w;
	assign result.state_changed = menu_next_w != menu_q;
	assign result.command       = cmd;
	assign result.rotation      = rot;
	assign result.position      = position_next;

endmodule

[rtl/encoder_menu_navigator.sv]
`timescale 1ns / 1ps
// Top level of the encoder menu navigator: input register, step core and
// result register. Depends on enm_pkg, enm_cfg_regs and enm_step_core.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    clock_pin data_pin switch_pin char_valid char_code
// out       output     out_valid/out_ready  menu_state state_changed command rotation position
// cfg       input      cfg_we               cfg_index cfg_data
//
// One beat is accepted per cycle sustained while the output is not stalled.
// Its result passes the input register, then the result register, and is offered from there.
// The step state (pin levels, position, menu) moves as a beat enters the result register.
// Reset clears both stages, the step state and the bounds (low 0, high 9).
// A stalled result holds; the input register still takes one more beat behind it.
module encoder_menu_navigator import enm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       clock_pin,
	input  logic       data_pin,
	input  logic       switch_pin,
	input  logic       char_valid,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] menu_state,
	output logic       state_changed,
	output logic [2:0] command,
	output logic [1:0] rotation,
	output logic [7:0] position,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t     cfg;
	in_item_t item_s1;
	logic     valid_s1;
	result_t  result;
	result_t  result_s2;
	logic     valid_s2;
	logic     advance;

	enm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A beat leaves the input register when the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.clock_pin  <= clock_pin;
			item_s1.data_pin   <= data_pin;
			item_s1.switch_pin <= switch_pin;
			item_s1.char_valid <= char_valid;
			item_s1.char_code  <= char_code;
		end
	end

	enm_step_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign menu_state    = result_s2.menu_state;
	assign state_changed = result_s2.state_changed;
	assign command       = result_s2.command;
	assign rotation      = result_s2.rotation;
	assign position      = result_s2.position;

endmodule

[rtl/enm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the encoder menu navigator and its bind to the top level.
// Depends on enm_pkg and encoder_menu_navigator_macros.svh.
`include "encoder_menu_navigator_macros.svh"
module enm_checker import enm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] menu_state,
	input logic       state_changed,
	input logic [2:0] command,
	input logic [1:0] rotation,
	input logic [7:0] position
);

	// A stalled result beat holds its menu state, position and command.
	`ENM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(menu_state) && $stable(position) && $stable(command))

	// The menu never leaves the table.
	`ENM_ASSERT_IMP(a_menu_range, clk, arst_n, out_valid, menu_state < 5'(MenuCount))

	// The menu changes only under an applied command.
	`ENM_ASSERT_IMP(a_change_cmd, clk, arst_n, out_valid && state_changed, command != CMD_NONE)

	// Only defined command and rotation codes are reported.
	`ENM_ASSERT_IMP(a_codes, clk, arst_n, out_valid, command <= CMD_BACK && rotation != 2'd3)

endmodule

bind encoder_menu_navigator enm_checker u_enm_checker (.*);
